### src/tpwf_pkg.sv
// ----------------------------------------------------------------------------
// tpwf_pkg
// Shared types and request codes for the two-part word fold hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpwf_pkg;

    // Request codes on the input channel
    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_CLOSE  = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // Fold and mix shift amounts
    localparam int FOLD_SHIFT = 3;
    localparam int MIX_SHIFT_A = 11;
    localparam int MIX_SHIFT_B = 13;
    localparam int MIX_SHIFT_C = 23;

    typedef logic [31:0] word_t;
    typedef logic [23:0] partial_t;

    // One operation handed from the front part to the back part
    typedef struct packed {
        word_t word;    // word to fold into the sum (zero folds nothing)
        logic  finish;  // emit the hash after folding
        logic  seen;    // key holds at least one string (finish only)
    } op_t;

    // Fold one word: w xor (w >> 3)
    function automatic word_t fold(input word_t w);
        fold = w ^ (w >> FOLD_SHIFT);
    endfunction

endpackage

`default_nettype wire

### src/tpwf_if.sv
// ----------------------------------------------------------------------------
// tpwf_req_if / tpwf_hash_if
// Valid/ready channels for request items and hash result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpwf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface tpwf_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

### src/tpwf_front.sv
// ----------------------------------------------------------------------------
// tpwf_front
// Accepts request items, packs bytes into big-endian words and issues fold
// and finish operations to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tpwf_front (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tpwf_req_if.sink      req,
    input  wire logic     q_ready,
    output tpwf_pkg::op_t q_op,
    output logic          q_push
);

    tpwf_pkg::partial_t collect_reg, collect_next;
    logic [1:0]         phase_reg, phase_next;
    logic               seen_reg, seen_next;
    logic               accept;

    assign req.ready = q_ready;
    assign accept    = req.valid && q_ready;

    // Classify the item and build the operation
    always_comb
    begin
        collect_next = collect_reg;
        phase_next   = phase_reg;
        seen_next    = seen_reg;
        q_push       = 1'b0;
        q_op.word    = {8'd0, collect_reg};
        q_op.finish  = 1'b0;
        q_op.seen    = seen_reg;
        if (accept)
        begin
            unique case (req.req_type)
                tpwf_pkg::REQ_BYTE:
                begin
                    if (phase_reg == 2'd3)
                    begin
                        q_push       = 1'b1;
                        q_op.word    = {collect_reg, req.data_byte};
                        collect_next = '0;
                        phase_next   = 2'd0;
                    end
                    else
                    begin
                        collect_next = {collect_reg[15:0], req.data_byte};
                        phase_next   = phase_reg + 2'd1;
                    end
                end
                tpwf_pkg::REQ_CLOSE:
                begin
                    q_push       = 1'b1;
                    collect_next = '0;
                    phase_next   = 2'd0;
                    seen_next    = 1'b1;
                end
                tpwf_pkg::REQ_FINISH:
                begin
                    // pending bytes fold in as an implicit close
                    q_push       = 1'b1;
                    q_op.finish  = 1'b1;
                    q_op.seen    = seen_reg || (phase_reg != 2'd0);
                    collect_next = '0;
                    phase_next   = 2'd0;
                    seen_next    = 1'b0;
                end
                default:
                begin
                    // unused code: drop the item
                end
            endcase
        end
    end

    // Hold packing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collect_reg <= '0;
            phase_reg   <= 2'd0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            collect_reg <= collect_next;
            phase_reg   <= phase_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

`default_nettype wire

### src/tpwf_queue.sv
// ----------------------------------------------------------------------------
// tpwf_queue
// Small FIFO of operations between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tpwf_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tpwf_pkg::op_t  push_op,
    output logic                push_ready,
    input  wire logic           pop,
    output tpwf_pkg::op_t       pop_op,
    output logic                pop_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tpwf_pkg::op_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Write storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow queue");

endmodule

`default_nettype wire

### src/tpwf_back.sv
// ----------------------------------------------------------------------------
// tpwf_back
// Folds words into the running sum, mixes the sum on finish and holds the
// hash result item until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tpwf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire tpwf_pkg::op_t q_op,
    output logic               q_pop,
    tpwf_hash_if.source        hash
);

    tpwf_pkg::word_t sum_reg;
    tpwf_pkg::word_t sum_plus;
    logic            fin_valid_reg;
    tpwf_pkg::word_t fin_sum_reg;
    logic            fin_seen_reg;
    logic            out_valid_reg;
    tpwf_pkg::word_t out_value_reg;
    tpwf_pkg::word_t mix_raw;
    tpwf_pkg::word_t mix_final;
    logic            out_free, fin_move, fin_free;

    assign out_free = !out_valid_reg || hash.ready;
    assign fin_move = fin_valid_reg && out_free;
    assign fin_free = !fin_valid_reg || fin_move;
    assign q_pop    = q_valid && (!q_op.finish || fin_free);

    assign sum_plus = sum_reg + tpwf_pkg::fold(q_op.word);

    // Mix the finished sum
    assign mix_raw = (fin_sum_reg + (fin_sum_reg >> tpwf_pkg::MIX_SHIFT_A))
                   + ((fin_sum_reg >> tpwf_pkg::MIX_SHIFT_B)
                   + (fin_sum_reg >> tpwf_pkg::MIX_SHIFT_C));
    assign mix_final = !fin_seen_reg ? '0 :
                       (mix_raw == '0) ? 32'd1 : mix_raw;

    // Payload of the finish stage and the output register
    always_ff @(posedge clk)
    begin
        if (q_pop && q_op.finish)
        begin
            fin_sum_reg  <= sum_plus;
            fin_seen_reg <= q_op.seen;
        end
        if (fin_move)
        begin
            out_value_reg <= mix_final;
        end
    end

    // Advance sum and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                sum_reg <= q_op.finish ? '0 : sum_plus;
            end
            if (q_pop && q_op.finish)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (fin_move)
            begin
                fin_valid_reg <= 1'b0;
            end
            if (fin_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (hash.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign hash.valid      = out_valid_reg;
    assign hash.hash_value = out_value_reg;

    a_finish_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_op.finish) |=> (sum_reg == '0))
        else $error("sum not cleared after finish");

    a_no_finish_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_op.finish) |-> fin_free)
        else $error("finish popped into a busy stage");

    a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        fin_move |=> out_valid_reg)
        else $error("finished hash lost before output");

endmodule

`default_nettype wire

### src/two_part_word_fold_hash.sv
// A finish item passes through the queue and the finish stage register into the
// output register. Throughput: one request item per cycle while the queue has
// room; the back folds one queued word per cycle with a single 32-bit adder,
// but a finish at the queue head waits until the finish stage is free.
// Result items wait in an output register; the queue absorbs output stalls.
// Reset (rst_n low, asynchronous) clears the sum, packing state, queue and
// all valid flags; the block is ready for requests as soon as it is released.
`default_nettype none

// ----------------------------------------------------------------------------
// two_part_word_fold_hash
// Byte-serial hash of a key of strings: front packs words, back folds and
// mixes them.
// ----------------------------------------------------------------------------
module two_part_word_fold_hash #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tpwf_req_if.sink    req,
    tpwf_hash_if.source hash
);

    tpwf_pkg::op_t push_op, pop_op;
    logic          push, push_ready, pop, pop_valid;

    tpwf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_ready (push_ready),
        .q_op    (push_op),
        .q_push  (push)
    );

    tpwf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_op     (pop_op),
        .pop_valid  (pop_valid)
    );

    tpwf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_op    (pop_op),
        .q_pop   (pop),
        .hash    (hash)
    );

endmodule

`default_nettype wire

### verif/two_part_word_fold_hash_tb.sv
// ----------------------------------------------------------------------------
// two_part_word_fold_hash_tb
// Drives keys of byte strings into the hash block and checks every emitted
// hash item against a local model of the word fold and final mix. A short
// table of directed requests comes first, then random keys with random gaps
// on both channels, one long output stall and one drain pause.
// ----------------------------------------------------------------------------
module two_part_word_fold_hash_tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 650;
    localparam int SINK_HOLD_CYCLES = 150;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 10;
    localparam int DIRECTED_COUNT = 22;

    typedef struct {
        logic [1:0]      req_type;
        logic [7:0]      data_byte;
        bit              typed;
        tpwf_pkg::word_t typed_hash;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tpwf_req_if  req_ch ();
    tpwf_hash_if hash_ch ();

    two_part_word_fold_hash uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .hash  (hash_ch)
    );

    // Model state of the key being hashed
    tpwf_pkg::word_t    key_sum;
    tpwf_pkg::partial_t pending_bytes;
    logic [1:0]         pending_count;
    bit                 string_closed;

    tpwf_pkg::word_t expected_hashes [$];
    int              mismatch_count;
    int              idle_cycles;
    int              counted_requests;
    bit              sender_calm;
    bit              sink_hold_request;
    bit              drain_done;
    stim_row_t       directed_rows [0:DIRECTED_COUNT-1];

    // Clock
    always #1 clk = ~clk;

    // Mostly no gap, some short, a few long; none at all in a calm stretch
    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Favor the extreme byte values now and then
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 8'h00;
        if (roll == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Fold the pending bytes of the open string and count it as a string
    function automatic void close_pending();
        tpwf_pkg::word_t w;
        w = {8'h00, pending_bytes};
        key_sum = key_sum + (w ^ (w >> tpwf_pkg::FOLD_SHIFT));
        pending_bytes = '0;
        pending_count = '0;
        string_closed = 1'b1;
    endfunction

    // Advance the model by one accepted request; queue the hash on finish
    function automatic void hash_request(input logic [1:0] rt, input logic [7:0] db,
                                         input bit typed,
                                         input tpwf_pkg::word_t typed_hash);
        tpwf_pkg::word_t w;
        tpwf_pkg::word_t mixed;
        case (rt)
            tpwf_pkg::REQ_BYTE:
            begin
                if (pending_count == 2'd3)
                begin
                    w = {pending_bytes, db};
                    key_sum = key_sum + (w ^ (w >> tpwf_pkg::FOLD_SHIFT));
                    pending_bytes = '0;
                    pending_count = '0;
                end
                else
                begin
                    pending_bytes = {pending_bytes[15:0], db};
                    pending_count = pending_count + 2'd1;
                end
            end
            tpwf_pkg::REQ_CLOSE:
                close_pending();
            tpwf_pkg::REQ_FINISH:
            begin
                if (pending_count != 2'd0)
                    close_pending();
                if (!string_closed)
                    mixed = '0;
                else
                begin
                    mixed = key_sum + (key_sum >> tpwf_pkg::MIX_SHIFT_A)
                          + (key_sum >> tpwf_pkg::MIX_SHIFT_B)
                          + (key_sum >> tpwf_pkg::MIX_SHIFT_C);
                    if (mixed == '0)
                        mixed = 32'd1;
                end
                expected_hashes.push_back(typed ? typed_hash : mixed);
                key_sum = '0;
                pending_bytes = '0;
                pending_count = '0;
                string_closed = 1'b0;
            end
            default:
                ;
        endcase
    endfunction

    // Offer one request item and hold it until accepted; call at a rising edge
    task automatic send_request(input logic [1:0] rt, input logic [7:0] db,
                                input bit typed = 1'b0,
                                input tpwf_pkg::word_t typed_hash = '0);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rt;
        req_ch.data_byte <= db;
        do
            @(posedge clk);
        while (!req_ch.ready);
        hash_request(rt, db, typed, typed_hash);
        if (rt != REQ_UNUSED)
            counted_requests++;
    endtask

    // Send one random key: mostly well formed, some broken or noisy
    task automatic send_random_key();
        int strings;
        int length;
        bit leave_open;
        sender_calm = ($urandom_range(3) == 0);
        if ($urandom_range(99) < 85)
        begin
            strings = $urandom_range(0, 3);
            leave_open = ($urandom_range(4) == 0);
            for (int s = 0; s < strings; s++)
            begin
                length = ($urandom_range(9) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(0, 9);
                for (int i = 0; i < length; i++)
                begin
                    if ($urandom_range(19) == 0)
                        send_request(REQ_UNUSED, pick_byte());
                    send_request(tpwf_pkg::REQ_BYTE, pick_byte());
                end
                if (!(leave_open && s == strings - 1))
                    send_request(tpwf_pkg::REQ_CLOSE, pick_byte());
            end
            send_request(tpwf_pkg::REQ_FINISH, pick_byte());
        end
        else
        begin
            length = $urandom_range(1, 8);
            for (int i = 0; i < length; i++)
                send_request(2'($urandom_range(3)), pick_byte());
        end
    endtask

    // Stimulus
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = tpwf_pkg::REQ_BYTE;
        req_ch.data_byte = 8'h00;
        key_sum = '0;
        pending_bytes = '0;
        pending_count = '0;
        string_closed = 1'b0;
        mismatch_count = 0;
        counted_requests = 0;
        sender_calm = 1'b0;
        sink_hold_request = 1'b0;
        drain_done = 1'b0;

        directed_rows = '{
            // empty key right after reset hashes to zero
            '{tpwf_pkg::REQ_FINISH, 8'h00, 1'b1, 32'h0000_0000},
            // one empty string: mixed zero is emitted as one
            '{tpwf_pkg::REQ_CLOSE,  8'hFF, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_FINISH, 8'h00, 1'b1, 32'h0000_0001},
            // whole words never closed leave no string behind
            '{tpwf_pkg::REQ_BYTE,   8'hFF, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_BYTE,   8'hFF, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_BYTE,   8'hFF, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_BYTE,   8'hFF, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_FINISH, 8'h00, 1'b1, 32'h0000_0000},
            // unused request code is dropped
            '{REQ_UNUSED,           8'hA5, 1'b0, 32'h0},
            // open string is folded on finish
            '{tpwf_pkg::REQ_BYTE,   8'h00, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_BYTE,   8'h80, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_FINISH, 8'h00, 1'b0, 32'h0},
            // three leftover bytes, then more than two strings
            '{tpwf_pkg::REQ_BYTE,   8'hFF, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_BYTE,   8'hFF, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_BYTE,   8'hFF, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_CLOSE,  8'h00, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_BYTE,   8'h7F, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_CLOSE,  8'h00, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_CLOSE,  8'h00, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_BYTE,   8'h01, 1'b0, 32'h0},
            '{REQ_UNUSED,           8'hFF, 1'b0, 32'h0},
            '{tpwf_pkg::REQ_FINISH, 8'h55, 1'b0, 32'h0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        sender_calm = 1'b1;
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_request(directed_rows[i].req_type, directed_rows[i].data_byte,
                         directed_rows[i].typed, directed_rows[i].typed_hash);

        // Random keys; stall the output early, drain once half way
        sink_hold_request = 1'b1;
        counted_requests = 0;
        while (counted_requests < RANDOM_REQUESTS)
        begin
            if (!drain_done && counted_requests >= RANDOM_REQUESTS / 2)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
                while (expected_hashes.size() != 0)
                    @(posedge clk);
                drain_done = 1'b1;
            end
            send_random_key();
        end
        req_ch.valid <= 1'b0;

        // Wait for the last hash items, then settle
        while (expected_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Output ready: random stretches, one long hold when asked
    initial
    begin
        int busy;
        int idle;
        bit calm;
        hash_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (sink_hold_request)
            begin
                sink_hold_request = 1'b0;
                hash_ch.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
            end
            calm = ($urandom_range(3) == 0);
            busy = $urandom_range(1, 12);
            hash_ch.ready <= 1'b1;
            repeat (busy) @(posedge clk);
            idle = pick_gap(calm);
            if (idle > 0)
            begin
                hash_ch.ready <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
    end

    // Compare hash items with the oldest expectation; watch for a hang
    always @(posedge clk)
    begin
        tpwf_pkg::word_t want;
        if (rst_n)
        begin
            if (hash_ch.valid && hash_ch.ready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $display("%0t: hash_value expected none got %h", $time,
                             hash_ch.hash_value);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (hash_ch.hash_value !== want)
                    begin
                        $display("%0t: hash_value expected %h got %h", $time, want,
                                 hash_ch.hash_value);
                        mismatch_count++;
                    end
                end
            end
            if ((hash_ch.valid && hash_ch.ready) || (req_ch.valid && req_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, %0d hash items outstanding", $time,
                         expected_hashes.size());
                $display("Mismatches found");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
        else
            idle_cycles <= 0;
    end

endmodule

### sim.f
src/tpwf_pkg.sv
src/tpwf_if.sv
src/tpwf_front.sv
src/tpwf_queue.sv
src/tpwf_back.sv
src/two_part_word_fold_hash.sv
verif/two_part_word_fold_hash_tb.sv
